// ----- rtl/core/tgarle_pkg.sv -----
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types and constants of the Targa run-length pixel decoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

   localparam int unsigned ADDR_WIDTH = 4;
   localparam int unsigned DATA_WIDTH = 32;

   localparam logic [1:0] REG_DEPTH_MODE   = 2'd0;
   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

   localparam int unsigned HDR_REPEAT_BIT = 7;

   typedef enum logic [1:0] {
      DEPTH_8  = 2'd0,
      DEPTH_16 = 2'd1,
      DEPTH_24 = 2'd2,
      DEPTH_32 = 2'd3
   } depth_type;

   typedef enum logic {
      ST_HEADER,
      ST_PIXEL
   } state_type;

   typedef struct packed {
      depth_type   depth_mode;
      logic [31:0] pixel_total;
   } cfg_type;

   typedef struct packed {
      logic [7:0] comp0;
      logic [7:0] comp1;
      logic [7:0] comp2;
      logic [7:0] comp3;
      logic [7:0] repeat_count;
      logic       image_done;
      logic       run_clamped;
   } pixel_type;

endpackage

// ----- rtl/core/tgarle_csr.sv -----
// ----------------------------------------------------------------------------
// tgarle_csr
// APB register file: pixel depth, image size and the registered pixel total.
// ----------------------------------------------------------------------------
module tgarle_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tgarle_pkg::ADDR_WIDTH-1:0]   paddr,
   input  logic [tgarle_pkg::DATA_WIDTH-1:0]   pwdata,
   output logic [tgarle_pkg::DATA_WIDTH-1:0]   prdata,
   output logic                                pready,
   output tgarle_pkg::cfg_type                 cfg
);

   tgarle_pkg::depth_type depth_ff, depth_in;
   logic [15:0]           width_ff, width_in;
   logic [15:0]           height_ff, height_in;
   logic [31:0]           total_ff, total_in;
   logic                  wr_en;
   logic [1:0]            reg_idx;
   logic [15:0]           mul_a;
   logic [15:0]           mul_b;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];

   always_comb begin
      depth_in  = depth_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         unique case (reg_idx)
            tgarle_pkg::REG_DEPTH_MODE:   depth_in  = tgarle_pkg::depth_type'(pwdata[1:0]);
            tgarle_pkg::REG_IMAGE_WIDTH:  width_in  = pwdata[15:0];
            tgarle_pkg::REG_IMAGE_HEIGHT: height_in = pwdata[15:0];
            default: ;
         endcase
      end
      // total follows the written value in the same edge
      mul_a    = width_in;
      mul_b    = height_in;
      total_in = 32'(mul_a) * 32'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= tgarle_pkg::DEPTH_24;
         width_ff  <= 16'd1;
         height_ff <= 16'd1;
         total_ff  <= 32'd1;
      end else begin
         depth_ff  <= depth_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         total_ff  <= total_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         tgarle_pkg::REG_DEPTH_MODE:   prdata = {30'd0, depth_ff};
         tgarle_pkg::REG_IMAGE_WIDTH:  prdata = {16'd0, width_ff};
         tgarle_pkg::REG_IMAGE_HEIGHT: prdata = {16'd0, height_ff};
         default:                      prdata = '0;
      endcase
   end

   assign cfg.depth_mode  = depth_ff;
   assign cfg.pixel_total = total_ff;

endmodule

// ----- rtl/core/tgarle_parser.sv -----
// ----------------------------------------------------------------------------
// tgarle_parser
// Packet state, pixel assembly, run clamping and the result register.
// ----------------------------------------------------------------------------
module tgarle_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  tgarle_pkg::cfg_type    cfg,
   input  logic                   in_valid,
   input  logic [7:0]             in_byte,
   output logic                   in_take,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tgarle_pkg::pixel_type  rsp
);

   tgarle_pkg::state_type state_ff, state_in;
   logic                  repeats_ff, repeats_in;
   logic [7:0]            left_ff, left_in;
   logic [1:0]            bip_ff, bip_in;
   logic [31:0]           asm_ff, asm_in;
   logic [31:0]           written_ff, written_in;
   logic                  cut_ff, cut_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   tgarle_pkg::pixel_type rsp_ff, rsp_in;

   logic [7:0]  hdr_run;
   logic [31:0] remain_raw;
   logic [31:0] remain;
   logic        hdr_cut;
   logic [7:0]  hdr_len;
   logic [31:0] asm_new;
   logic        pix_done;
   logic [7:0]  left_dec;
   logic        raw_last;
   logic [7:0]  emit_count;
   logic        emit_cut;
   logic [31:0] written_sum;
   logic        img_done;
   logic        pkt_end;
   logic        emit;

   function automatic logic [31:0] format_pixel(tgarle_pkg::depth_type depth,
                                                logic [31:0] p);
      logic [31:0] r;
      unique case (depth)
         tgarle_pkg::DEPTH_8:  r = {24'd0, p[7:0]};
         tgarle_pkg::DEPTH_16: r = {8'd0, p[14:10], 3'd0, p[9:5], 3'd0, p[4:0], 3'd0};
         tgarle_pkg::DEPTH_24: r = {8'd0, p[23:0]};
         tgarle_pkg::DEPTH_32: r = p;
         default:              r = p;
      endcase
      return r;
   endfunction

   assign in_take = in_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      hdr_run    = {1'b0, in_byte[6:0]} + 8'd1;
      remain_raw = (cfg.pixel_total > written_ff) ? cfg.pixel_total - written_ff : 32'd0;
      remain     = (remain_raw == 32'd0) ? 32'd1 : remain_raw;
      hdr_cut    = {24'd0, hdr_run} > remain;
      hdr_len    = hdr_cut ? remain[7:0] : hdr_run;

      asm_new  = ((bip_ff == 2'd0) ? 32'd0 : asm_ff) | ({24'd0, in_byte} << {bip_ff, 3'b000});
      pix_done = bip_ff >= cfg.depth_mode;

      left_dec = (left_ff != 8'd0) ? left_ff - 8'd1 : 8'd0;
      raw_last = left_dec == 8'd0;

      emit_count  = repeats_ff ? ((left_ff == 8'd0) ? 8'd1 : left_ff) : 8'd1;
      emit_cut    = repeats_ff ? cut_ff : (raw_last && cut_ff);
      written_sum = written_ff + {24'd0, emit_count};
      img_done    = written_sum >= cfg.pixel_total;
      pkt_end     = repeats_ff || raw_last || img_done;
      emit        = in_take && (state_ff == tgarle_pkg::ST_PIXEL) && pix_done;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      if (in_take) begin
         unique case (state_ff)
            tgarle_pkg::ST_HEADER: state_in = tgarle_pkg::ST_PIXEL;
            tgarle_pkg::ST_PIXEL: begin
               if (pix_done && pkt_end) begin
                  state_in = tgarle_pkg::ST_HEADER;
               end
            end
            default: state_in = tgarle_pkg::ST_HEADER;
         endcase
      end
   end

   // datapath and result
   always_comb begin
      repeats_in = repeats_ff;
      left_in    = left_ff;
      bip_in     = bip_ff;
      asm_in     = asm_ff;
      written_in = written_ff;
      cut_in     = cut_ff;
      if (in_take) begin
         unique case (state_ff)
            tgarle_pkg::ST_HEADER: begin
               repeats_in = in_byte[tgarle_pkg::HDR_REPEAT_BIT];
               left_in    = hdr_len;
               bip_in     = 2'd0;
               cut_in     = hdr_cut;
            end
            tgarle_pkg::ST_PIXEL: begin
               asm_in = asm_new;
               if (!pix_done) begin
                  bip_in = bip_ff + 2'd1;
               end else begin
                  bip_in     = 2'd0;
                  written_in = img_done ? 32'd0 : written_sum;
                  left_in    = (img_done || repeats_ff) ? 8'd0 : left_dec;
                  cut_in     = pkt_end ? 1'b0 : cut_ff;
               end
            end
            default: ;
         endcase
      end

      {rsp_in.comp3, rsp_in.comp2, rsp_in.comp1, rsp_in.comp0} =
         format_pixel(cfg.depth_mode, asm_new);
      rsp_in.repeat_count = emit_count;
      rsp_in.image_done   = img_done;
      rsp_in.run_clamped  = emit_cut;

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tgarle_pkg::ST_HEADER;
         repeats_ff   <= 1'b0;
         left_ff      <= 8'd0;
         bip_ff       <= 2'd0;
         written_ff   <= 32'd0;
         cut_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         repeats_ff   <= repeats_in;
         left_ff      <= left_in;
         bip_ff       <= bip_in;
         written_ff   <= written_in;
         cut_ff       <= cut_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      asm_ff <= asm_in;
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- rtl/core/tga_rle_pixel_decoder.sv -----
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Targa run-length pixel stream decoder, one coded byte per beat.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock, sustained, as long as result beats are
// taken when offered: an input register and a result register bound the
// packet logic, which finishes every byte in one cycle. A result beat left
// waiting by rsp_ready low holds the input register, and req_ready drops once
// that register holds a byte. The last byte of a pixel passes the input register
// and then the result register before its beat is valid. Header bytes and
// partial pixel bytes give no result. Repeat packets give one beat with the run
// as repeat_count; raw packets give one beat per pixel. Runs are clamped at
// width*height, and the decoder restarts at a header after the last pixel.
// Register writes take effect on the next edge and do not reset the decoding.
module tga_rle_pixel_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_data_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_comp0,
   output logic [7:0]                          rsp_comp1,
   output logic [7:0]                          rsp_comp2,
   output logic [7:0]                          rsp_comp3,
   output logic [7:0]                          rsp_repeat_count,
   output logic                                rsp_image_done,
   output logic                                rsp_run_clamped,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tgarle_pkg::ADDR_WIDTH-1:0]   paddr,
   input  logic [tgarle_pkg::DATA_WIDTH-1:0]   pwdata,
   output logic [tgarle_pkg::DATA_WIDTH-1:0]   prdata,
   output logic                                pready
);

   tgarle_pkg::cfg_type   cfg;
   tgarle_pkg::pixel_type rsp;
   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_take;
   logic                  req_beat;

   tgarle_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_ready = !in_valid_ff || in_take;
   assign req_beat  = req_valid && req_ready;

   always_comb begin
      if (req_beat) begin
         in_valid_in = 1'b1;
      end else if (in_take) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_byte_ff <= req_data_byte;
      end
   end

   tgarle_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (in_valid_ff),
      .in_byte   (in_byte_ff),
      .in_take   (in_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_comp0        = rsp.comp0;
   assign rsp_comp1        = rsp.comp1;
   assign rsp_comp2        = rsp.comp2;
   assign rsp_comp3        = rsp.comp3;
   assign rsp_repeat_count = rsp.repeat_count;
   assign rsp_image_done   = rsp.image_done;
   assign rsp_run_clamped  = rsp.run_clamped;

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_repeat_count != 8'd0) && (rsp_repeat_count <= 8'd128))
      else $error("repeat count out of range");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && rsp_valid && !rsp_ready)
      else $error("input stalled without a blocked result");

   a_take_frees: assert property (@(posedge clock) disable iff (reset)
      in_take && !req_valid |=> !in_valid_ff)
      else $error("input register not released");
`endif

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Targa run-length pixel decoder.
// ----------------------------------------------------------------------------
// Coded stream bytes go in through a valid/ready driver. Each accepted byte is
// run through a local decoder model, which queues the pixel beat it predicts.
// A monitor compares every result beat with the oldest queued prediction.
// A directed opening covers the 8-bit and 16-bit depths, image size extremes,
// clamped runs, a packet with no pixels left, and a depth change inside a
// pixel. Then random phases follow: a new register setting, mostly well-formed
// packets, and some stray bytes. Both sides stall in random bursts; the last
// stretch runs without stalls.
// ----------------------------------------------------------------------------
module tb;

   localparam int DRAIN_CYCLES = 8;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_comp0, rsp_comp1, rsp_comp2, rsp_comp3, rsp_repeat_count;
   logic        rsp_image_done, rsp_run_clamped;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [tgarle_pkg::ADDR_WIDTH-1:0] paddr = '0;
   logic [tgarle_pkg::DATA_WIDTH-1:0] pwdata = '0;
   logic [tgarle_pkg::DATA_WIDTH-1:0] prdata;
   logic        pready;

   // decoder model state
   tgarle_pkg::depth_type cfg_depth = tgarle_pkg::DEPTH_24;
   logic [15:0] cfg_width = 16'd1;
   logic [15:0] cfg_height = 16'd1;
   bit          awaiting_header = 1'b1;
   bit          repeat_packet = 1'b0;
   bit          packet_cut = 1'b0;
   logic [31:0] pkt_left = '0;
   logic [1:0]  bytes_held = '0;
   logic [31:0] assembled = '0;
   logic [31:0] pixels_done = '0;

   logic [7:0]  stream_bytes[$];
   tgarle_pkg::pixel_type pending_pixels[$];
   tgarle_pkg::pixel_type got, want;

   int  mismatches = 0;
   int  idle_odds = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   bit  req_taken = 1'b0;

   tga_rle_pixel_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_comp0        (rsp_comp0),
      .rsp_comp1        (rsp_comp1),
      .rsp_comp2        (rsp_comp2),
      .rsp_comp3        (rsp_comp3),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_image_done   (rsp_image_done),
      .rsp_run_clamped  (rsp_run_clamped),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [31:0] pixel_total();
      return 32'(cfg_width) * 32'(cfg_height);
   endfunction

   function automatic void decode_byte(input logic [7:0] b);
      logic [31:0] total, remain, count;
      bit          cut, last;
      tgarle_pkg::pixel_type px;
      total = pixel_total();
      if (awaiting_header) begin
         count = 32'(b[6:0]) + 32'd1;
         remain = (total > pixels_done) ? total - pixels_done : 32'd0;
         if (remain == 0) remain = 32'd1;
         packet_cut = count > remain;
         if (packet_cut) count = remain;
         repeat_packet = b[tgarle_pkg::HDR_REPEAT_BIT];
         pkt_left = count;
         bytes_held = '0;
         assembled = '0;
         awaiting_header = 1'b0;
         return;
      end
      if (bytes_held == 0) assembled = '0;
      assembled |= 32'(b) << (8 * bytes_held);
      if (int'(bytes_held) < int'(cfg_depth)) begin
         bytes_held++;
         return;
      end
      bytes_held = '0;

      if (repeat_packet) begin
         count = (pkt_left == 0) ? 32'd1 : pkt_left;
         cut = packet_cut;
         pkt_left = '0;
         awaiting_header = 1'b1;
         packet_cut = 1'b0;
      end else begin
         if (pkt_left > 0) pkt_left--;
         last = pkt_left == 0;
         cut = last && packet_cut;
         if (last) begin
            awaiting_header = 1'b1;
            packet_cut = 1'b0;
         end
         count = 32'd1;
      end

      px = '0;
      case (cfg_depth)
         tgarle_pkg::DEPTH_8: begin
            px.comp0 = assembled[7:0];
         end
         tgarle_pkg::DEPTH_16: begin
            px.comp0 = {assembled[4:0], 3'b000};
            px.comp1 = {assembled[9:5], 3'b000};
            px.comp2 = {assembled[14:10], 3'b000};
         end
         tgarle_pkg::DEPTH_24: begin
            px.comp0 = assembled[7:0];
            px.comp1 = assembled[15:8];
            px.comp2 = assembled[23:16];
         end
         default: begin
            px.comp0 = assembled[7:0];
            px.comp1 = assembled[15:8];
            px.comp2 = assembled[23:16];
            px.comp3 = assembled[31:24];
         end
      endcase
      pixels_done += count;
      px.repeat_count = count[7:0];
      px.image_done = pixels_done >= total;
      px.run_clamped = cut;
      if (px.image_done) begin
         pixels_done = '0;
         awaiting_header = 1'b1;
         pkt_left = '0;
         packet_cut = 1'b0;
      end
      pending_pixels.push_back(px);
   endfunction

   function automatic logic [15:0] pick_side();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return 16'hFFFF;
      if (roll == 1) return 16'd1;
      return 16'($urandom_range(1, 12));
   endfunction

   // sender: beats change on the falling edge
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap = send_gap - 1;
         end else if (stream_bytes.size() > 0) begin
            req_valid <= 1'b1;
            req_data_byte <= stream_bytes.pop_front();
            if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
               send_gap = $urandom_range(1, 7);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
         rsp_ready <= 1'b0;
         recv_gap = recv_gap - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            recv_gap = $urandom_range(1, 7);
      end
   end

   // monitor
   always @(posedge clock) begin
      req_taken = req_valid && req_ready;
      if (!reset) begin
         if (req_taken) decode_byte(req_data_byte);
         if (rsp_valid && rsp_ready) begin
            got.comp0 = rsp_comp0;
            got.comp1 = rsp_comp1;
            got.comp2 = rsp_comp2;
            got.comp3 = rsp_comp3;
            got.repeat_count = rsp_repeat_count;
            got.image_done = rsp_image_done;
            got.run_clamped = rsp_run_clamped;
            if (pending_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected pixel beat: c=%h %h %h %h rpt=%0d done=%b clamp=%b",
                     got.comp0, got.comp1, got.comp2, got.comp3, got.repeat_count,
                     got.image_done, got.run_clamped);
            end else begin
               want = pending_pixels.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("pixel mismatch: exp c=%h %h %h %h rpt=%0d done=%b clamp=%b",
                        want.comp0, want.comp1, want.comp2, want.comp3, want.repeat_count,
                        want.image_done, want.run_clamped);
                     $display("                got c=%h %h %h %h rpt=%0d done=%b clamp=%b",
                        got.comp0, got.comp1, got.comp2, got.comp3, got.repeat_count,
                        got.image_done, got.run_clamped);
                  end
               end
            end
         end
      end
   end

   // write a register, then read it back
   task automatic csr_write(input logic [1:0] idx, input logic [15:0] value);
      logic [31:0] rd_mask;
      rd_mask = (idx == tgarle_pkg::REG_DEPTH_MODE) ? 32'h3 : 32'hFFFF;
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= 32'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (idx)
         tgarle_pkg::REG_DEPTH_MODE:   cfg_depth = tgarle_pkg::depth_type'(value[1:0]);
         tgarle_pkg::REG_IMAGE_WIDTH:  cfg_width = value;
         tgarle_pkg::REG_IMAGE_HEIGHT: cfg_height = value;
         default: ;
      endcase
      @(negedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if ((prdata & rd_mask) !== (32'(value) & rd_mask)) begin
         mismatches++;
         if (mismatches <= 10)
            $display("register %0d read %h, wrote %h", idx, prdata, value);
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // sender holds off until every pixel is back and the pipe is empty
   task automatic wait_idle();
      while (stream_bytes.size() != 0 || req_valid || pending_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      static logic [7:0] seq_a[10] = '{8'h82, 8'hFF, 8'h7F, 8'h00, 8'hA5,
                                       8'h11, 8'h22, 8'h33, 8'hFF, 8'h5A};
      static logic [7:0] seq_b[6] = '{8'h80, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h80};
      static logic [7:0] seq_c[2] = '{8'h83, 8'h34};
      static logic [7:0] seq_d[5] = '{8'h56, 8'h05, 8'h01, 8'h02, 8'h03};
      int          random_bytes, phase_end, bpp, roll, n;
      logic [31:0] img_left, total, run, kept;
      bit          is_rep;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_odds = 3;

      // 8-bit, 4x2: repeat, raw cut at image end, oversize repeat on a new image
      csr_write(tgarle_pkg::REG_DEPTH_MODE, 16'(tgarle_pkg::DEPTH_8));
      csr_write(tgarle_pkg::REG_IMAGE_WIDTH, 16'd4);
      csr_write(tgarle_pkg::REG_IMAGE_HEIGHT, 16'd2);
      foreach (seq_a[i]) stream_bytes.push_back(seq_a[i]);
      wait_idle();

      // 16-bit on the largest image
      csr_write(tgarle_pkg::REG_DEPTH_MODE, 16'(tgarle_pkg::DEPTH_16));
      csr_write(tgarle_pkg::REG_IMAGE_WIDTH, 16'hFFFF);
      csr_write(tgarle_pkg::REG_IMAGE_HEIGHT, 16'hFFFF);
      foreach (seq_b[i]) stream_bytes.push_back(seq_b[i]);
      wait_idle();

      // shrink below what is written: next packet has no pixels left
      csr_write(tgarle_pkg::REG_IMAGE_WIDTH, 16'd1);
      csr_write(tgarle_pkg::REG_IMAGE_HEIGHT, 16'd1);
      foreach (seq_c[i]) stream_bytes.push_back(seq_c[i]);
      wait_idle();

      // depth drops inside a half-read pixel
      csr_write(tgarle_pkg::REG_DEPTH_MODE, 16'(tgarle_pkg::DEPTH_8));
      foreach (seq_d[i]) stream_bytes.push_back(seq_d[i]);

      random_bytes = 0;
      while (random_bytes < 600) begin
         wait_idle();
         roll = $urandom_range(0, 2);
         if (random_bytes > 480) idle_odds = 0;
         else idle_odds = (roll == 0) ? 0 : (roll == 1) ? 3 : 10;
         if ($urandom_range(0, 2) != 0)
            csr_write(tgarle_pkg::REG_DEPTH_MODE, 16'($urandom_range(0, 3)));
         if ($urandom_range(0, 2) != 0)
            csr_write(tgarle_pkg::REG_IMAGE_WIDTH, pick_side());
         if ($urandom_range(0, 2) != 0)
            csr_write(tgarle_pkg::REG_IMAGE_HEIGHT, pick_side());

         total = pixel_total();
         img_left = (total > pixels_done) ? total - pixels_done : 32'd0;
         bpp = int'(cfg_depth) + 1;
         phase_end = random_bytes + $urandom_range(20, 80);
         while (random_bytes < phase_end) begin
            if ($urandom_range(0, 6) == 0) begin
               // stray bytes and cut-off packets
               n = $urandom_range(1, 4);
               repeat (n) begin
                  stream_bytes.push_back(8'($urandom));
                  random_bytes++;
               end
            end else begin
               if (img_left == 0) img_left = total;
               is_rep = 1'($urandom_range(0, 1));
               roll = $urandom_range(0, 9);
               if (is_rep)
                  run = (roll == 0) ? 32'd128 : 32'($urandom_range(1, 128));
               else if (roll < 3 && img_left <= 6)
                  run = 32'($urandom_range(img_left, 128));
               else
                  run = 32'($urandom_range(1, 6));
               kept = (run < img_left) ? run : img_left;
               img_left -= kept;
               stream_bytes.push_back({is_rep, 7'(run - 1)});
               random_bytes++;
               n = is_rep ? bpp : int'(kept) * bpp;
               repeat (n) begin
                  stream_bytes.push_back(8'($urandom));
                  random_bytes++;
               end
            end
         end
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: errors");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/tgarle_pkg.sv
rtl/core/tgarle_csr.sv
rtl/core/tgarle_parser.sv
rtl/core/tga_rle_pixel_decoder.sv
bench/tb.sv
